// File: hw/rtl/tws_pkg.sv
// Shared constants of the trilinear wrap texture sampler.
package tws_pkg;

    // Input item kinds
    localparam logic [1:0] KIND_SAMPLE      = 2'd0;
    localparam logic [1:0] KIND_LOAD_FINE   = 2'd1;
    localparam logic [1:0] KIND_LOAD_COARSE = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_FINE_WIDTH    = 3'd0;
    localparam logic [2:0] REG_FINE_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_COARSE_WIDTH  = 3'd2;
    localparam logic [2:0] REG_COARSE_HEIGHT = 3'd3;
    localparam logic [2:0] REG_LEVEL_BLEND   = 3'd4;

    localparam int SIZE_BITS  = 7;
    localparam int FRAC_BITS  = 16;
    localparam int COORD_BITS = 32;
    localparam int OUT_BITS   = 16;

endpackage

// File: hw/rtl/tws_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
module tws_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/tws_lerp.sv
// Registered linear interpolation of one channel: (a*(1-f) + b*f) >> 16.
module tws_lerp #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                    i_clk,
    input  logic [CHANNEL_BITS-1:0] i_a,
    input  logic [CHANNEL_BITS-1:0] i_b,
    input  logic [16:0]             i_f,
    output logic [CHANNEL_BITS-1:0] o_mix
);

    logic [CHANNEL_BITS+16:0] r_pa;
    logic [CHANNEL_BITS+16:0] r_pb;
    logic [16:0]              one_minus;
    logic [CHANNEL_BITS+17:0] sum;

    assign one_minus = 17'h10000 - i_f;

    // Multiply both sides, then add and truncate
    always_ff @(posedge i_clk) begin
        r_pa <= (CHANNEL_BITS+17)'(i_a) * (CHANNEL_BITS+17)'(one_minus);
        r_pb <= (CHANNEL_BITS+17)'(i_b) * (CHANNEL_BITS+17)'(i_f);
    end

    assign sum   = (CHANNEL_BITS+18)'(r_pa) + (CHANNEL_BITS+18)'(r_pb);
    assign o_mix = sum[CHANNEL_BITS+15:16];

endmodule

// File: hw/rtl/trilinear_wrap_texture_sampler.sv
// Top level of the trilinear wrap texture sampler.
//
// Loads may follow one another with no gap. A sample holds busy high from its
// acceptance until its corner reads are done. Busy first covers the stages that
// scale and wrap the coordinates. Then each level's memory
// delivers one corner texel a cycle, because each store has a single read port.
// No new item is taken until busy falls. The filter pipeline behind the reads
// runs on its own. The result appears on o_out_* with o_valid high for one
// cycle. The receiver cannot hold the result off. Texels hold three channels of
// CHANNEL_BITS bits each, and the stores are MAX_SIDE*MAX_SIDE entries deep.
module trilinear_wrap_texture_sampler
    import tws_pkg::*;
#(
    parameter int MAX_SIDE     = 64,
    parameter int CHANNEL_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_kind,
    input  logic signed [31:0]    i_coord_u,
    input  logic signed [31:0]    i_coord_v,
    input  logic [11:0]           i_texel_index,
    input  logic [15:0]           i_load_red,
    input  logic [15:0]           i_load_green,
    input  logic [15:0]           i_load_blue,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data,
    output logic                  o_valid,
    output logic [15:0]           o_out_red,
    output logic [15:0]           o_out_green,
    output logic [15:0]           o_out_blue
);

    localparam int DEPTH   = MAX_SIDE * MAX_SIDE;
    localparam int ABITS   = $clog2(DEPTH);
    localparam int SBITS   = $clog2(MAX_SIDE + 1);
    localparam int TW      = 3 * CHANNEL_BITS;
    localparam int PBITS   = COORD_BITS + SBITS + 1;
    localparam int LOWBITS = PBITS - FRAC_BITS;
    localparam int CB      = CHANNEL_BITS;

    typedef enum logic [1:0] {S_IDLE, S_READ} t_state;

    // Per-level address state
    typedef struct packed {
        logic [SBITS-1:0] w;
        logic [SBITS-1:0] x0;
        logic [SBITS-1:0] x1;
        logic [SBITS-1:0] y0;
        logic [SBITS-1:0] y1;
        logic [15:0]      fx;
        logic [15:0]      fy;
    } t_level;

    // ---------------------------------------------------------------------
    // Configuration registers
    logic [SIZE_BITS-1:0] r_fine_w, r_fine_h, r_coarse_w, r_coarse_h;
    logic [15:0]          r_blend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fine_w   <= '0;
            r_fine_h   <= '0;
            r_coarse_w <= '0;
            r_coarse_h <= '0;
            r_blend    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FINE_WIDTH:    r_fine_w   <= i_cfg_data[SIZE_BITS-1:0];
                REG_FINE_HEIGHT:   r_fine_h   <= i_cfg_data[SIZE_BITS-1:0];
                REG_COARSE_WIDTH:  r_coarse_w <= i_cfg_data[SIZE_BITS-1:0];
                REG_COARSE_HEIGHT: r_coarse_h <= i_cfg_data[SIZE_BITS-1:0];
                REG_LEVEL_BLEND:   r_blend    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp a size register to MAX_SIDE
    function automatic logic [SBITS-1:0] side_of(input logic [SIZE_BITS-1:0] r);
        logic [31:0] rv;
        rv = 32'(r);
        if (rv > 32'(MAX_SIDE)) begin
            return SBITS'(MAX_SIDE);
        end
        return SBITS'(r);
    endfunction

    logic [SBITS-1:0] fw, fh, cw, ch;
    assign fw = side_of(r_fine_w);
    assign fh = side_of(r_fine_h);
    assign cw = side_of(r_coarse_w);
    assign ch = side_of(r_coarse_h);

    // ---------------------------------------------------------------------
    // Accept and first stage: scale the fractional part of each coordinate by
    // the level size less half a texel; whole tiles drop out of the wrap
    logic accept, acc_sample, acc_load_f, acc_load_c;
    assign accept     = start && !busy;
    assign acc_sample = accept && (i_kind == KIND_SAMPLE);
    assign acc_load_f = accept && (i_kind == KIND_LOAD_FINE) && (32'(i_texel_index) < DEPTH);
    assign acc_load_c = accept && (i_kind == KIND_LOAD_COARSE) && (32'(i_texel_index) < DEPTH);

    logic                    r_s1_vld;
    logic signed [PBITS-1:0] r_tu_f, r_tv_f, r_tu_c, r_tv_c;
    logic [SBITS-1:0]        r_s1_fw, r_s1_fh, r_s1_cw, r_s1_ch;
    logic                    r_s1_black, r_s1_fonly;

    function automatic logic signed [PBITS-1:0] scale(input logic [FRAC_BITS-1:0] c,
                                                      input logic [SBITS-1:0] s);
        return PBITS'($signed({1'b0, c})) * PBITS'($signed({1'b0, s})) - PBITS'(32768);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= acc_sample;
        end
        if (acc_sample) begin
            r_tu_f     <= scale(i_coord_u[FRAC_BITS-1:0], fw);
            r_tv_f     <= scale(i_coord_v[FRAC_BITS-1:0], fh);
            r_tu_c     <= scale(i_coord_u[FRAC_BITS-1:0], cw);
            r_tv_c     <= scale(i_coord_v[FRAC_BITS-1:0], ch);
            r_s1_fw    <= fw;
            r_s1_fh    <= fh;
            r_s1_cw    <= cw;
            r_s1_ch    <= ch;
            r_s1_black <= (fw == '0) || (fh == '0);
            r_s1_fonly <= (r_blend == '0) || (cw == '0) || (ch == '0);
        end
    end

    // ---------------------------------------------------------------------
    // Second stage: wrap the low texel and its neighbour into the level.
    // With only the fractional coordinate scaled, the low texel lies in
    // -1 .. size-1, and -1 wraps to the last texel.
    function automatic logic [SBITS-1:0] wrap_low(input logic signed [PBITS-1:0] t,
                                                  input logic [SBITS-1:0] s);
        logic signed [LOWBITS-1:0] low;
        low = t[PBITS-1:FRAC_BITS];
        if (low < 0) begin
            return s - SBITS'(1);
        end
        return SBITS'(low);
    endfunction

    function automatic logic [SBITS-1:0] next_of(input logic [SBITS-1:0] x,
                                                 input logic [SBITS-1:0] s);
        return (x + SBITS'(1) == s) ? '0 : x + SBITS'(1);
    endfunction

    logic   r_s2_vld;
    t_level r_lf, r_lc;
    logic   r_s2_black, r_s2_fonly;
    logic [SBITS-1:0] fx0, fy0, cx0, cy0;

    assign fx0 = (r_s1_fw == '0) ? '0 : wrap_low(r_tu_f, r_s1_fw);
    assign fy0 = (r_s1_fh == '0) ? '0 : wrap_low(r_tv_f, r_s1_fh);
    assign cx0 = (r_s1_cw == '0) ? '0 : wrap_low(r_tu_c, r_s1_cw);
    assign cy0 = (r_s1_ch == '0) ? '0 : wrap_low(r_tv_c, r_s1_ch);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        if (r_s1_vld) begin
            r_lf <= '{w: r_s1_fw, x0: fx0, x1: next_of(fx0, r_s1_fw),
                      y0: fy0, y1: next_of(fy0, r_s1_fh),
                      fx: r_tu_f[15:0], fy: r_tv_f[15:0]};
            r_lc <= '{w: r_s1_cw, x0: cx0, x1: next_of(cx0, r_s1_cw),
                      y0: cy0, y1: next_of(cy0, r_s1_ch),
                      fx: r_tu_c[15:0], fy: r_tv_c[15:0]};
            r_s2_black <= r_s1_black;
            r_s2_fonly <= r_s1_fonly;
        end
    end

    // ---------------------------------------------------------------------
    // Read sequencer: four corner reads per level, one a cycle
    t_state     r_state;
    logic [1:0] r_corner;
    t_level     r_rf, r_rc;
    logic       r_rd_black, r_rd_fonly;

    assign busy = r_s1_vld || r_s2_vld || (r_state == S_READ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_corner <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (r_s2_vld) begin
                        r_state  <= S_READ;
                        r_corner <= '0;
                    end
                end
                S_READ: begin
                    r_corner <= r_corner + 2'd1;
                    if (r_corner == 2'd3) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (r_s2_vld) begin
            r_rf       <= r_lf;
            r_rc       <= r_lc;
            r_rd_black <= r_s2_black;
            r_rd_fonly <= r_s2_fonly;
        end
    end

    function automatic logic [ABITS-1:0] corner_addr(input t_level l, input logic [1:0] k);
        logic [SBITS-1:0]   x;
        logic [SBITS-1:0]   y;
        logic [2*SBITS:0]   a;
        x = k[0] ? l.x1 : l.x0;
        y = k[1] ? l.y1 : l.y0;
        a = (2*SBITS+1)'(y) * (2*SBITS+1)'(l.w) + (2*SBITS+1)'(x);
        return ABITS'(a);
    endfunction

    logic             reading;
    logic [ABITS-1:0] f_raddr, c_raddr, load_addr;
    logic [TW-1:0]    f_rdata, c_rdata, load_word;

    assign reading   = (r_state == S_READ);
    assign f_raddr   = corner_addr(r_rf, r_corner);
    assign c_raddr   = corner_addr(r_rc, r_corner);
    assign load_addr = ABITS'(i_texel_index);
    assign load_word = {CB'(i_load_blue), CB'(i_load_green), CB'(i_load_red)};

    tws_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_fine_store (
        .i_clk  (i_clk),
        .i_we   (acc_load_f),
        .i_waddr(load_addr),
        .i_wdata(load_word),
        .i_raddr(f_raddr),
        .o_rdata(f_rdata)
    );

    tws_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_coarse_store (
        .i_clk  (i_clk),
        .i_we   (acc_load_c),
        .i_waddr(load_addr),
        .i_wdata(load_word),
        .i_raddr(c_raddr),
        .o_rdata(c_rdata)
    );

    // ---------------------------------------------------------------------
    // Collect the corners as they return
    logic            r_rv;
    logic [1:0]      r_rk;
    logic [TW-1:0]   r_fq [4];
    logic [TW-1:0]   r_cq [4];
    logic            r_gather_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv          <= 1'b0;
            r_gather_done <= 1'b0;
        end else begin
            r_rv          <= reading;
            r_gather_done <= r_rv && (r_rk == 2'd3);
        end
        r_rk <= r_corner;
        if (r_rv) begin
            r_fq[r_rk] <= f_rdata;
            r_cq[r_rk] <= c_rdata;
        end
    end

    // ---------------------------------------------------------------------
    // Horizontal pass: six lerps (top and bottom, three channels) per level, then the vertical and level lerps
    logic [CB-1:0] f_top [3], f_bot [3], c_top [3], c_bot [3];
    logic [CB-1:0] f_bil [3], c_bil [3], mixed [3];

    genvar k;
    generate
        for (k = 0; k < 3; k++) begin : g_ch
            tws_lerp #(.CHANNEL_BITS(CB)) u_ft (.i_clk(i_clk),
                .i_a(r_fq[0][k*CB +: CB]), .i_b(r_fq[1][k*CB +: CB]),
                .i_f({1'b0, r_rf.fx}), .o_mix(f_top[k]));
            tws_lerp #(.CHANNEL_BITS(CB)) u_fb (.i_clk(i_clk),
                .i_a(r_fq[2][k*CB +: CB]), .i_b(r_fq[3][k*CB +: CB]),
                .i_f({1'b0, r_rf.fx}), .o_mix(f_bot[k]));
            tws_lerp #(.CHANNEL_BITS(CB)) u_ct (.i_clk(i_clk),
                .i_a(r_cq[0][k*CB +: CB]), .i_b(r_cq[1][k*CB +: CB]),
                .i_f({1'b0, r_rc.fx}), .o_mix(c_top[k]));
            tws_lerp #(.CHANNEL_BITS(CB)) u_cb (.i_clk(i_clk),
                .i_a(r_cq[2][k*CB +: CB]), .i_b(r_cq[3][k*CB +: CB]),
                .i_f({1'b0, r_rc.fx}), .o_mix(c_bot[k]));
            tws_lerp #(.CHANNEL_BITS(CB)) u_fv (.i_clk(i_clk),
                .i_a(f_top[k]), .i_b(f_bot[k]),
                .i_f({1'b0, r_rf.fy}), .o_mix(f_bil[k]));
            tws_lerp #(.CHANNEL_BITS(CB)) u_cv (.i_clk(i_clk),
                .i_a(c_top[k]), .i_b(c_bot[k]),
                .i_f({1'b0, r_rc.fy}), .o_mix(c_bil[k]));
            tws_lerp #(.CHANNEL_BITS(CB)) u_lv (.i_clk(i_clk),
                .i_a(f_bil[k]), .i_b(c_bil[k]),
                .i_f({1'b0, r_blend}), .o_mix(mixed[k]));
        end
    endgenerate

    // Track the pass through the three lerp stages; hold flags alongside
    logic [2:0] r_pipe;
    logic       r_black, r_fonly;
    logic [CB-1:0] r_fhold [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_pipe  <= {r_pipe[1:0], r_gather_done};
            o_valid <= r_pipe[2];
        end
        if (r_gather_done) begin
            r_black <= r_rd_black;
            r_fonly <= r_rd_fonly;
        end
        if (r_pipe[1]) begin
            r_fhold <= f_bil;
        end
        if (r_pipe[2]) begin
            o_out_red   <= r_black ? '0 : OUT_BITS'(r_fonly ? r_fhold[0] : mixed[0]);
            o_out_green <= r_black ? '0 : OUT_BITS'(r_fonly ? r_fhold[1] : mixed[1]);
            o_out_blue  <= r_black ? '0 : OUT_BITS'(r_fonly ? r_fhold[2] : mixed[2]);
        end
    end

endmodule

// File: hw/rtl/tws_checker.sv
// Port-level checker of the trilinear wrap texture sampler, bound to the top level.
module tws_checker
    import tws_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_kind,
    input logic        o_valid
);

    // A sample makes the block busy from the next cycle
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == KIND_SAMPLE) |=> busy)
        else $error("sample accepted without busy");

    // Results are single-cycle strobes
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe repeated");

    // A result follows every accepted sample
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == KIND_SAMPLE) |-> ##12 o_valid)
        else $error("sample result missing");

    // No result comes out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result during reset");

endmodule

bind trilinear_wrap_texture_sampler tws_checker u_tws_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .i_kind (i_kind),
    .o_valid(o_valid)
);
